/* hdl/brun_pkg.sv */
package brun_pkg;

  localparam int WORD_BITS    = 64;
  localparam int WORD_IDX_W   = 6;   // bit index inside a map word
  localparam int GROUP_BITS   = 8;   // slots handled per scan step
  localparam int GROUP_IDX_W  = 3;
  localparam int OP_W         = 3;
  localparam int IDX_W        = 10;
  localparam int LEN_W        = 11;
  localparam int ST_W         = 2;
  localparam int WSEL_W       = LEN_W - WORD_IDX_W;  // word index of an 11-bit slot
  localparam int CMP_W        = 17;  // holds the largest map size
  localparam int MAP_BITS_DEF = 1024;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC      = 3'd0,
    OP_MARK_USED  = 3'd1,
    OP_MARK_FREE  = 3'd2,
    OP_CHECK_USED = 3'd3,
    OP_CHECK_FREE = 3'd4
  } brun_op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK         = 2'd0,
    ST_NO_SPACE   = 2'd1,
    ST_CHECK_FAIL = 2'd2,
    ST_RANGE      = 2'd3
  } brun_status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_GRP,
    S_RUN_RD,
    S_RUN_MOD,
    S_RESP
  } brun_state_e;

  typedef struct packed {
    logic clear;
    logic step;
  } scan_ctl_t;

  typedef struct packed {
    logic                   hit;
    logic [GROUP_IDX_W-1:0] pos;
  } scan_res_t;

endpackage

/* hdl/brun_if.sv */
interface brun_cmd_if import brun_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [IDX_W-1:0] first_bit;
  logic [IDX_W-1:0] last_bit;
  logic [LEN_W-1:0] run_length;

  modport source (output valid, output operation, output first_bit, output last_bit,
                  output run_length, input ready);
  modport sink   (input valid, input operation, input first_bit, input last_bit,
                  input run_length, output ready);
endinterface

interface brun_rsp_if import brun_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] found_index;

  modport source (output valid, output status, output found_index, input ready);
  modport sink   (input valid, input status, input found_index, output ready);
endinterface

/* hdl/bitmap_run_allocator_top.sv */
// Channel   Dir  Payload                                          Word accepted when
// cmd_i     in   operation, first_bit, last_bit, run_length      valid && ready
// rsp_o     out  status, found_index                             valid && ready
//
// After reset the map is swept to all free, one word a cycle: MAP_WORDS words
// (16 at the default size) before cmd_i.ready first rises.
// One command at a time. Rejected or trivial commands go straight to S_RESP, which registers the result.
// Allocate: each map word scanned is read, then its slots in the window are checked
// 8 per step by the 8-slot run counter, then each word of the run is read and modified.
// Mark/check: each word touched is read, then modified/written.
// A waiting result does not block cmd_i; a stalled rsp_o holds the next result back.
module bitmap_run_allocator_top import brun_pkg::*; #(
  parameter int MAP_BITS = MAP_BITS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  brun_cmd_if.sink   cmd_i,
  brun_rsp_if.source rsp_o
);

  localparam int MAP_WORDS = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

  // map port
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [WORD_BITS-1:0]  mem_rdata;

  // run counter
  scan_ctl_t             scan_ctl;
  scan_res_t             scan_res;
  logic [GROUP_BITS-1:0] scan_free;
  logic [LEN_W-1:0]      scan_len;

  brun_seq #(
    .MAP_BITS  (MAP_BITS),
    .MAP_WORDS (MAP_WORDS),
    .AW        (AW)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_i),
    .rsp_o       (rsp_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata),
    .scan_ctl_o  (scan_ctl),
    .scan_free_o (scan_free),
    .scan_len_o  (scan_len),
    .scan_res_i  (scan_res)
  );

  // free map, 1 = free, registered read
  brun_map #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // counts the free run 8 slots per step, flags the first slot that completes it
  brun_scan u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .free_i (scan_free),
    .len_i  (scan_len),
    .res_o  (scan_res)
  );

endmodule

/* hdl/brun_map.sv */
module brun_map import brun_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  logic [WORD_BITS-1:0] wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output logic [WORD_BITS-1:0] rdata_o
);

  logic [WORD_BITS-1:0] mem_q [DEPTH];
  logic [WORD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/brun_scan.sv */
module brun_scan import brun_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctl_t             ctl_i,
  input  logic [GROUP_BITS-1:0] free_i,
  input  logic [LEN_W-1:0]      len_i,
  output scan_res_t             res_o
);

  // length of the free run ending just before the current group
  logic [LEN_W-1:0] count_q, count_d;
  logic [LEN_W-1:0] cnt;
  scan_res_t        res;

  always_comb begin
    cnt     = count_q;
    res.hit = 1'b0;
    res.pos = '0;
    for (int i = 0; i < GROUP_BITS; i++) begin
      if (!res.hit) begin
        if (free_i[i]) begin
          cnt = cnt + LEN_W'(1);
          if (cnt == len_i) begin
            res.hit = 1'b1;
            res.pos = GROUP_IDX_W'(i);
          end
        end else begin
          cnt = '0;
        end
      end
    end
    count_d = count_q;
    if (ctl_i.clear) begin
      count_d = '0;
    end else if (ctl_i.step) begin
      count_d = cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign res_o = res;

endmodule

/* hdl/brun_seq.sv */
module brun_seq import brun_pkg::*; #(
  parameter int MAP_BITS  = MAP_BITS_DEF,
  parameter int MAP_WORDS = (MAP_BITS_DEF + WORD_BITS - 1) / WORD_BITS,
  parameter int AW        = 4
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  brun_cmd_if.sink              cmd_i,
  brun_rsp_if.source            rsp_o,
  output logic                  mem_we_o,
  output logic [AW-1:0]         mem_waddr_o,
  output logic [WORD_BITS-1:0]  mem_wdata_o,
  output logic                  mem_re_o,
  output logic [AW-1:0]         mem_raddr_o,
  input  logic [WORD_BITS-1:0]  mem_rdata_i,
  output scan_ctl_t             scan_ctl_o,
  output logic [GROUP_BITS-1:0] scan_free_o,
  output logic [LEN_W-1:0]      scan_len_o,
  input  scan_res_t             scan_res_i
);

  brun_state_e      state_q, state_d;
  logic [OP_W-1:0]  op_q, op_d;
  logic [IDX_W-1:0] first_q, first_d;
  logic [IDX_W-1:0] last_q, last_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [IDX_W-1:0] slot_q, slot_d;     // base slot of the group being scanned
  logic [WSEL_W-1:0] w_q, w_d;          // word of the run pass
  logic [LEN_W-1:0] rs_q, rs_d;         // run first slot
  logic [LEN_W-1:0] re_q, re_d;         // run last slot
  logic [AW-1:0]    clr_q, clr_d;
  brun_status_e     status_q, status_d;
  logic [IDX_W-1:0] found_q, found_d;
  logic             rsp_valid_q, rsp_valid_d;
  brun_status_e     rsp_status_q, rsp_status_d;
  logic [IDX_W-1:0] rsp_found_q, rsp_found_d;

  logic [AW+WSEL_W-1:0]  run_addr_ext, scan_addr_ext;
  logic [AW-1:0]         run_addr, scan_addr;
  logic [LEN_W-1:0]      sum_len;
  logic                  alloc_oor, run_oor;
  logic [GROUP_BITS-1:0] grp_bits;
  logic [GROUP_BITS-1:0] grp_free;
  logic [LEN_W-1:0]      hit_slot, found_calc;
  logic [WORD_IDX_W-1:0] lo, hi;
  logic [WORD_BITS-1:0]  mask;
  logic                  fail;

  assign run_addr_ext  = {{AW{1'b0}}, w_q};
  assign run_addr      = run_addr_ext[AW-1:0];
  assign scan_addr_ext = {{AW{1'b0}}, 1'b0, slot_q[IDX_W-1:WORD_IDX_W]};
  assign scan_addr     = scan_addr_ext[AW-1:0];

  assign sum_len   = {1'b0, cmd_i.first_bit} + cmd_i.run_length;
  assign run_oor   = CMP_W'(sum_len) > CMP_W'(MAP_BITS);
  assign alloc_oor = (CMP_W'(cmd_i.first_bit) >= CMP_W'(MAP_BITS)) ||
                     (CMP_W'(cmd_i.last_bit) >= CMP_W'(MAP_BITS));

  // current group, slots outside [first, last] read as used
  assign grp_bits = mem_rdata_i[{slot_q[WORD_IDX_W-1:GROUP_IDX_W], 3'b000} +: GROUP_BITS];
  always_comb begin
    for (int i = 0; i < GROUP_BITS; i++) begin
      grp_free[i] = grp_bits[i] &&
        ({slot_q[IDX_W-1:GROUP_IDX_W], GROUP_IDX_W'(i)} >= first_q) &&
        ({slot_q[IDX_W-1:GROUP_IDX_W], GROUP_IDX_W'(i)} <= last_q);
    end
  end

  assign hit_slot   = {1'b0, slot_q[IDX_W-1:GROUP_IDX_W], scan_res_i.pos};
  assign found_calc = hit_slot - len_q + LEN_W'(1);

  // run mask inside the current word
  assign lo   = (w_q == rs_q[LEN_W-1:WORD_IDX_W]) ? rs_q[WORD_IDX_W-1:0] : '0;
  assign hi   = (w_q == re_q[LEN_W-1:WORD_IDX_W]) ? re_q[WORD_IDX_W-1:0] : '1;
  assign mask = ({WORD_BITS{1'b1}} << lo) &
                ({WORD_BITS{1'b1}} >> (WORD_IDX_W'(WORD_BITS - 1) - hi));

  assign scan_free_o = grp_free;
  assign scan_len_o  = len_q;

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    first_d      = first_q;
    last_d       = last_q;
    len_d        = len_q;
    slot_d       = slot_q;
    w_d          = w_q;
    rs_d         = rs_q;
    re_d         = re_q;
    clr_d        = clr_q;
    status_d     = status_q;
    found_d      = found_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    rsp_status_d = rsp_status_q;
    rsp_found_d  = rsp_found_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = run_addr;
    mem_wdata_o  = mem_rdata_i;
    mem_re_o     = 1'b0;
    mem_raddr_o  = run_addr;
    scan_ctl_o   = '0;
    cmd_i.ready  = (state_q == S_IDLE);
    fail         = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = clr_q;
        mem_wdata_o = '1;
        if (clr_q == AW'(MAP_WORDS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end
      S_IDLE: begin
        if (cmd_i.valid) begin
          op_d     = cmd_i.operation;
          first_d  = cmd_i.first_bit;
          last_d   = cmd_i.last_bit;
          len_d    = cmd_i.run_length;
          status_d = ST_OK;
          found_d  = '0;
          state_d  = S_RESP;
          unique case (cmd_i.operation) inside
            OP_ALLOC: begin
              if (alloc_oor) begin
                status_d = ST_RANGE;
              end else if (cmd_i.run_length == '0 ||
                           cmd_i.first_bit > cmd_i.last_bit) begin
                status_d = ST_NO_SPACE;
              end else begin
                slot_d           = {cmd_i.first_bit[IDX_W-1:GROUP_IDX_W], 3'b000};
                scan_ctl_o.clear = 1'b1;
                state_d          = S_SCAN_RD;
              end
            end
            OP_MARK_USED, OP_MARK_FREE, OP_CHECK_USED, OP_CHECK_FREE: begin
              if (run_oor) begin
                status_d = ST_RANGE;
              end else if (cmd_i.run_length != '0) begin
                rs_d    = {1'b0, cmd_i.first_bit};
                re_d    = sum_len - LEN_W'(1);
                w_d     = {1'b0, cmd_i.first_bit[IDX_W-1:WORD_IDX_W]};
                state_d = S_RUN_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        mem_re_o    = 1'b1;
        mem_raddr_o = scan_addr;
        state_d     = S_SCAN_GRP;
      end
      S_SCAN_GRP: begin
        scan_ctl_o.step = 1'b1;
        if (scan_res_i.hit) begin
          rs_d    = found_calc;
          re_d    = hit_slot;
          found_d = found_calc[IDX_W-1:0];
          w_d     = found_calc[LEN_W-1:WORD_IDX_W];
          state_d = S_RUN_RD;
        end else if (slot_q[IDX_W-1:GROUP_IDX_W] == last_q[IDX_W-1:GROUP_IDX_W]) begin
          status_d = ST_NO_SPACE;
          state_d  = S_RESP;
        end else begin
          slot_d = slot_q + IDX_W'(GROUP_BITS);
          if (slot_d[WORD_IDX_W-1:GROUP_IDX_W] == '0) begin
            state_d = S_SCAN_RD;
          end
        end
      end
      S_RUN_RD: begin
        mem_re_o = 1'b1;
        state_d  = S_RUN_MOD;
      end
      S_RUN_MOD: begin
        unique case (op_q)
          OP_CHECK_USED: fail = |(mem_rdata_i & mask);
          OP_CHECK_FREE: fail = |(~mem_rdata_i & mask);
          OP_MARK_FREE: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i | mask;
          end
          default: begin
            mem_we_o    = 1'b1;
            mem_wdata_o = mem_rdata_i & ~mask;
          end
        endcase
        if (fail) begin
          status_d = ST_CHECK_FAIL;
          state_d  = S_RESP;
        end else if (w_q == re_q[LEN_W-1:WORD_IDX_W]) begin
          state_d = S_RESP;
        end else begin
          w_d     = w_q + WSEL_W'(1);
          state_d = S_RUN_RD;
        end
      end
      S_RESP: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          rsp_status_d = status_q;
          rsp_found_d  = found_q;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    first_q      <= first_d;
    last_q       <= last_d;
    len_q        <= len_d;
    slot_q       <= slot_d;
    w_q          <= w_d;
    rs_q         <= rs_d;
    re_q         <= re_d;
    status_q     <= status_d;
    found_q      <= found_d;
    rsp_status_q <= rsp_status_d;
    rsp_found_q  <= rsp_found_d;
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_status_q;
  assign rsp_o.found_index = rsp_found_q;

`ifndef NO_ASSERTIONS
  a_we_only_mark : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == S_CLEAR) ||
                 (state_q == S_RUN_MOD && op_q != OP_CHECK_USED && op_q != OP_CHECK_FREE))
    else $error("map written outside clear or marking");

  a_hit_in_window : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_GRP && scan_res_i.hit) |->
      (found_calc >= {1'b0, first_q}) && (hit_slot <= {1'b0, last_q}))
    else $error("allocated run outside scan window");

  a_run_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN_RD) |-> (w_q <= re_q[LEN_W-1:WORD_IDX_W]))
    else $error("run pass went past its last word");

  a_rsp_from_resp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_q) |-> $past(state_q) == S_RESP)
    else $error("response raised outside result state");
`endif

endmodule
